// File: sv/tlbpt_pkg.sv
package tlbpt_pkg;

   // Fixed field widths
   localparam int ADDR_W      = 16;
   localparam int FRAME_OUT_W = 8;
   localparam int COUNT_W     = 16;
   localparam int RSP_DATA_W  = 56;
   localparam int RSP_USER_W  = 2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

   // tuser bit positions on the result channel
   localparam int USER_TLB_HIT    = 0;
   localparam int USER_PAGE_FAULT = 1;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_REDUCE,
      ST_SCAN,
      ST_PT_READ,
      ST_PT_CHECK,
      ST_FINISH
   } state_type;

   // Strobes to the TLB store
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } tlb_cmd_type;

   // Strobes to the page table memory
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } pt_cmd_type;

endpackage

// File: sv/tlbpt_tlb.sv
module tlbpt_tlb
   import tlbpt_pkg::*;
#(
   parameter int TLB_ENTRIES = 16,
   parameter int IDX_W       = 4,
   parameter int PAGE_W      = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  tlb_cmd_type       cmd,
   input  logic [IDX_W-1:0]  rd_addr,
   input  logic [PAGE_W-1:0] page,
   input  logic [IDX_W-1:0]  wr_addr,
   input  logic [PAGE_W-1:0] wr_tag,
   input  logic [PAGE_W-1:0] wr_frame,
   output logic              match,
   output logic [PAGE_W-1:0] rd_frame
);

   // Valid bits in flops, cleared by reset
   logic [TLB_ENTRIES-1:0] valid_ff;
   logic                   rd_valid_ff;

   // Tag and frame store
   logic [PAGE_W-1:0] tag_mem   [TLB_ENTRIES];
   logic [PAGE_W-1:0] frame_mem [TLB_ENTRIES];
   logic [PAGE_W-1:0] rd_tag_ff;
   logic [PAGE_W-1:0] rd_frame_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (cmd.wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (cmd.rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         tag_mem[wr_addr]   <= wr_tag;
         frame_mem[wr_addr] <= wr_frame;
      end
      if (cmd.rd_en) begin
         rd_tag_ff   <= tag_mem[rd_addr];
         rd_frame_ff <= frame_mem[rd_addr];
      end
   end

   // Shared tag comparator on the registered read
   assign match    = rd_valid_ff && (rd_tag_ff == page);
   assign rd_frame = rd_frame_ff;

endmodule

// File: sv/tlbpt_page_table.sv
module tlbpt_page_table
   import tlbpt_pkg::*;
#(
   parameter int PAGE_COUNT = 256,
   parameter int PAGE_W     = 8
) (
   input  logic              clock,
   input  pt_cmd_type        cmd,
   input  logic [PAGE_W-1:0] wr_addr,
   input  logic              wr_valid,
   input  logic [PAGE_W-1:0] wr_frame,
   input  logic [PAGE_W-1:0] rd_addr,
   output logic              rd_valid,
   output logic [PAGE_W-1:0] rd_frame
);

   // Each entry: valid bit above the frame number
   logic [PAGE_W:0] map_mem [PAGE_COUNT];
   logic [PAGE_W:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         map_mem[wr_addr] <= {wr_valid, wr_frame};
      end
      if (cmd.rd_en) begin
         rd_data_ff <= map_mem[rd_addr];
      end
   end

   assign rd_valid = rd_data_ff[PAGE_W];
   assign rd_frame = rd_data_ff[PAGE_W-1:0];

endmodule

// File: sv/tlb_page_table_translator.sv
// An access is accepted in the idle state. When the page field can reach PAGE_COUNT or more, it
// is first reduced modulo PAGE_COUNT; a TLB miss then reads the page table and refills the TLB.
// The TLB is searched one entry a cycle through a single tag comparator, lowest entry first.
// One access at a time: the next request is taken only in the idle state, which is entered as
// the result is registered; while the result output stalls, the block waits in the finish state.
// Reset is synchronous; afterwards the page table is cleared one entry a cycle over all
// PAGE_COUNT entries, during which req_tready stays low.
module tlb_page_table_translator
   import tlbpt_pkg::*;
#(
   parameter int TLB_ENTRIES = 16,
   parameter int PAGE_COUNT  = 256,
   parameter int OFFSET_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [ADDR_W-1:0]     req_tdata,  // [15:0] logical_address
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // [15:0] physical_address, [23:16] frame_index,
                                             // [39:24] hit_count, [55:40] fault_count
   output logic [RSP_USER_W-1:0] rsp_tuser   // [0] tlb_hit, [1] page_fault
);

   localparam int PAGE_W     = $clog2(PAGE_COUNT);
   localparam int REM_W      = PAGE_W + 1;
   localparam int VPN_W      = (ADDR_W - OFFSET_BITS > 0) ? ADDR_W - OFFSET_BITS : 1;
   localparam int RED_W      = $clog2(VPN_W + 1);
   localparam int TLB_IDX_W  = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
   localparam int TLB_CNT_W  = $clog2(TLB_ENTRIES + 1);
   localparam bit NEED_MOD   = (1 << VPN_W) > PAGE_COUNT;

   state_type state_ff, state_in;

   // Control registers
   logic [PAGE_W-1:0]    clr_cnt_ff, clr_cnt_in;
   logic [RED_W-1:0]     red_cnt_ff, red_cnt_in;
   logic [TLB_CNT_W-1:0] issue_cnt_ff, issue_cnt_in;
   logic                 cmp_pend_ff, cmp_pend_in;
   logic                 cmp_last_ff, cmp_last_in;
   logic [TLB_IDX_W-1:0] fill_ptr_ff, fill_ptr_in;
   logic [PAGE_W-1:0]    next_free_ff, next_free_in;
   logic [COUNT_W-1:0]   hits_ff, hits_in;
   logic [COUNT_W-1:0]   faults_ff, faults_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Payload registers
   logic [VPN_W-1:0]       vpn_ff, vpn_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic [PAGE_W-1:0]      page_ff, page_in;
   logic [PAGE_W-1:0]      frame_ff, frame_in;
   logic                   hit_ff, hit_in;
   logic                   fault_ff, fault_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0]  rsp_user_ff, rsp_user_in;

   // Sub-block connections
   tlb_cmd_type       tlb_cmd;
   logic              tlb_match;
   logic [PAGE_W-1:0] tlb_rd_frame;
   pt_cmd_type        pt_cmd;
   logic [PAGE_W-1:0] pt_wr_addr;
   logic              pt_wr_valid;
   logic              pt_rd_valid;
   logic [PAGE_W-1:0] pt_rd_frame;

   // Status terms shared by next-state and output logic
   logic              req_xfer;
   logic              scan_hit;
   logic              scan_miss;
   logic              scan_issue;
   logic              rsp_free;
   logic              clr_done;
   logic              red_done;
   logic [REM_W-1:0]  rem_shift;
   logic [PAGE_W-1:0] frame_sel;
   logic [PAGE_W-1:0] phys_frame_part;

   assign req_xfer   = (state_ff == ST_IDLE) && req_tvalid;
   assign scan_hit   = cmp_pend_ff && tlb_match;
   assign scan_miss  = cmp_pend_ff && !tlb_match && cmp_last_ff;
   assign scan_issue = (issue_cnt_ff < TLB_CNT_W'(TLB_ENTRIES)) && !scan_hit;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign clr_done   = (clr_cnt_ff == PAGE_W'(PAGE_COUNT - 1));
   assign red_done   = (red_cnt_ff == RED_W'(1));
   assign rem_shift  = {page_ff, vpn_ff[VPN_W-1]};
   assign frame_sel  = pt_rd_valid ? pt_rd_frame : next_free_ff;
   assign phys_frame_part = frame_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_xfer) state_in = NEED_MOD ? ST_REDUCE : ST_SCAN;
         end
         ST_REDUCE: begin
            if (red_done) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_hit) begin
               state_in = ST_FINISH;
            end else if (scan_miss) begin
               state_in = ST_PT_READ;
            end
         end
         ST_PT_READ: begin
            state_in = ST_PT_CHECK;
         end
         ST_PT_CHECK: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control strobes
   always_comb begin
      req_tready    = 1'b0;
      tlb_cmd.rd_en = 1'b0;
      tlb_cmd.wr_en = 1'b0;
      pt_cmd.rd_en  = 1'b0;
      pt_cmd.wr_en  = 1'b0;
      pt_wr_addr    = page_ff;
      pt_wr_valid   = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            pt_cmd.wr_en = 1'b1;
            pt_wr_addr   = clr_cnt_ff;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_SCAN: begin
            tlb_cmd.rd_en = scan_issue;
         end
         ST_PT_READ: begin
            pt_cmd.rd_en = 1'b1;
         end
         ST_PT_CHECK: begin
            tlb_cmd.wr_en = 1'b1;
            pt_cmd.wr_en  = !pt_rd_valid;
            pt_wr_valid   = 1'b1;
         end
         ST_REDUCE, ST_FINISH: begin
         end
         default: begin
         end
      endcase
   end

   // Datapath and counters
   always_comb begin
      clr_cnt_in   = clr_cnt_ff;
      red_cnt_in   = red_cnt_ff;
      issue_cnt_in = '0;
      cmp_pend_in  = 1'b0;
      cmp_last_in  = cmp_last_ff;
      fill_ptr_in  = fill_ptr_ff;
      next_free_in = next_free_ff;
      hits_in      = hits_ff;
      faults_in    = faults_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      vpn_in       = vpn_ff;
      offset_in    = offset_ff;
      page_in      = page_ff;
      frame_in     = frame_ff;
      hit_in       = hit_ff;
      fault_in     = fault_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + PAGE_W'(1);
         end
         ST_IDLE: begin
            if (req_xfer) begin
               vpn_in     = VPN_W'(req_tdata >> OFFSET_BITS);
               offset_in  = OFFSET_BITS'(req_tdata);
               red_cnt_in = RED_W'(VPN_W);
               page_in    = NEED_MOD ? '0 : PAGE_W'(VPN_W'(req_tdata >> OFFSET_BITS));
            end
         end
         // Restoring remainder, one page bit a cycle
         ST_REDUCE: begin
            vpn_in     = vpn_ff << 1;
            red_cnt_in = red_cnt_ff - RED_W'(1);
            if (rem_shift >= REM_W'(PAGE_COUNT)) begin
               page_in = PAGE_W'(rem_shift - REM_W'(PAGE_COUNT));
            end else begin
               page_in = PAGE_W'(rem_shift);
            end
         end
         // Issue one TLB read a cycle, compare the previous one
         ST_SCAN: begin
            if (scan_issue) begin
               issue_cnt_in = issue_cnt_ff + TLB_CNT_W'(1);
               cmp_pend_in  = 1'b1;
               cmp_last_in  = (issue_cnt_ff == TLB_CNT_W'(TLB_ENTRIES - 1));
            end else begin
               issue_cnt_in = issue_cnt_ff;
            end
            if (scan_hit) begin
               frame_in = tlb_rd_frame;
               hit_in   = 1'b1;
               fault_in = 1'b0;
            end
         end
         // Resolve the miss: allocate on a fault, refill the TLB
         ST_PT_CHECK: begin
            frame_in = frame_sel;
            hit_in   = 1'b0;
            fault_in = !pt_rd_valid;
            if (!pt_rd_valid) begin
               next_free_in = (next_free_ff == PAGE_W'(PAGE_COUNT - 1)) ?
                              '0 : next_free_ff + PAGE_W'(1);
            end
            fill_ptr_in = (fill_ptr_ff == TLB_IDX_W'(TLB_ENTRIES - 1)) ?
                          '0 : fill_ptr_ff + TLB_IDX_W'(1);
         end
         ST_FINISH: begin
            if (rsp_free) begin
               if (hit_ff && (hits_ff != COUNT_MAX)) begin
                  hits_in = hits_ff + COUNT_W'(1);
               end
               if (fault_ff && (faults_ff != COUNT_MAX)) begin
                  faults_in = faults_ff + COUNT_W'(1);
               end
               rsp_valid_in = 1'b1;
               rsp_data_in  = {faults_in, hits_in, FRAME_OUT_W'(frame_ff),
                               ADDR_W'({phys_frame_part, offset_ff})};
               rsp_user_in[USER_TLB_HIT]    = hit_ff;
               rsp_user_in[USER_PAGE_FAULT] = fault_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         red_cnt_ff   <= '0;
         issue_cnt_ff <= '0;
         cmp_pend_ff  <= 1'b0;
         cmp_last_ff  <= 1'b0;
         fill_ptr_ff  <= '0;
         next_free_ff <= '0;
         hits_ff      <= '0;
         faults_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         red_cnt_ff   <= red_cnt_in;
         issue_cnt_ff <= issue_cnt_in;
         cmp_pend_ff  <= cmp_pend_in;
         cmp_last_ff  <= cmp_last_in;
         fill_ptr_ff  <= fill_ptr_in;
         next_free_ff <= next_free_in;
         hits_ff      <= hits_in;
         faults_ff    <= faults_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      vpn_ff      <= vpn_in;
      offset_ff   <= offset_in;
      page_ff     <= page_in;
      frame_ff    <= frame_in;
      hit_ff      <= hit_in;
      fault_ff    <= fault_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   tlbpt_tlb #(
      .TLB_ENTRIES (TLB_ENTRIES),
      .IDX_W       (TLB_IDX_W),
      .PAGE_W      (PAGE_W)
   ) u_tlb (
      .clock    (clock),
      .reset    (reset),
      .cmd      (tlb_cmd),
      .rd_addr  (issue_cnt_ff[TLB_IDX_W-1:0]),
      .page     (page_ff),
      .wr_addr  (fill_ptr_ff),
      .wr_tag   (page_ff),
      .wr_frame (frame_sel),
      .match    (tlb_match),
      .rd_frame (tlb_rd_frame)
   );

   tlbpt_page_table #(
      .PAGE_COUNT (PAGE_COUNT),
      .PAGE_W     (PAGE_W)
   ) u_page_table (
      .clock    (clock),
      .cmd      (pt_cmd),
      .wr_addr  (pt_wr_addr),
      .wr_valid (pt_wr_valid),
      .wr_frame (next_free_ff),
      .rd_addr  (page_ff),
      .rd_valid (pt_rd_valid),
      .rd_frame (pt_rd_frame)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// File: test/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import tlbpt_pkg::*;

   localparam int TLB_DEPTH      = 16;
   localparam int PAGES          = 256;
   localparam int OFF_BITS       = 8;
   localparam int RANDOM_ITEMS   = 1500;
   localparam int STALL_CYCLES   = 300;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 2 * (TLB_DEPTH + 5);
   localparam int POOL_MAX       = 24;

   // One translated access as the block reports it
   typedef struct packed {
      logic [ADDR_W-1:0]      phys;
      logic [FRAME_OUT_W-1:0] frame;
      logic                   hit;
      logic                   fault;
      logic [COUNT_W-1:0]     hits;
      logic [COUNT_W-1:0]     faults;
   } translation_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [ADDR_W-1:0]     req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   // Shadow of the translator state
   logic                   map_valid [PAGES];
   logic [7:0]             map_frame [PAGES];
   logic                   tlb_valid [TLB_DEPTH];
   logic [7:0]             tlb_page  [TLB_DEPTH];
   logic [7:0]             tlb_frame [TLB_DEPTH];
   logic [3:0]             fill_ptr    = '0;
   logic [7:0]             next_frame  = '0;
   logic [COUNT_W-1:0]     hit_total   = '0;
   logic [COUNT_W-1:0]     fault_total = '0;

   translation_type pending_translations [$];

   int  fail_count    = 0;
   bit  idle_on       = 1'b1;
   bit  stall_request = 1'b0;
   int  stall_left    = 0;

   tlb_page_table_translator #(
      .TLB_ENTRIES (TLB_DEPTH),
      .PAGE_COUNT  (PAGES),
      .OFFSET_BITS (OFF_BITS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      for (int i = 0; i < PAGES; i++) begin
         map_valid[i] = 1'b0;
         map_frame[i] = '0;
      end
      for (int i = 0; i < TLB_DEPTH; i++) begin
         tlb_valid[i] = 1'b0;
         tlb_page[i]  = '0;
         tlb_frame[i] = '0;
      end
   end

   // TLB search, page table walk with demand allocation, FIFO refill
   function automatic translation_type translate_address(input logic [ADDR_W-1:0] addr);
      translation_type res;
      logic [7:0]      page;
      logic [7:0]      frame;
      logic            hit;
      page      = 8'((addr >> OFF_BITS) % PAGES);
      frame     = '0;
      hit       = 1'b0;
      res.fault = 1'b0;
      // lowest matching valid entry wins
      for (int i = 0; i < TLB_DEPTH; i++) begin
         if (!hit && tlb_valid[i] && tlb_page[i] == page) begin
            hit   = 1'b1;
            frame = tlb_frame[i];
         end
      end
      if (hit) begin
         if (hit_total != COUNT_MAX) hit_total++;
      end else begin
         if (map_valid[page]) begin
            frame = map_frame[page];
         end else begin
            // page fault: take the next frame, allocator wraps at the page count
            frame           = next_frame;
            next_frame      = 8'((next_frame + 1) % PAGES);
            map_valid[page] = 1'b1;
            map_frame[page] = frame;
            res.fault       = 1'b1;
            if (fault_total != COUNT_MAX) fault_total++;
         end
         tlb_valid[fill_ptr] = 1'b1;
         tlb_page[fill_ptr]  = page;
         tlb_frame[fill_ptr] = frame;
         fill_ptr            = 4'((fill_ptr + 1) % TLB_DEPTH);
      end
      res.phys   = 16'((32'(frame) << OFF_BITS) | (32'(addr) & ((32'd1 << OFF_BITS) - 1)));
      res.frame  = frame;
      res.hit    = hit;
      res.hits   = hit_total;
      res.faults = fault_total;
      return res;
   endfunction

   // Offer one address and wait for its transfer
   task automatic send_address(input logic [ADDR_W-1:0] addr);
      while (idle_on && $urandom_range(99) < 29) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= addr;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_translations.push_back(translate_address(addr));
   endtask

   task automatic wait_for_results();
      while (pending_translations.size() != 0) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // Result side: check each transfer, then pick the next tready
   initial begin : result_monitor
      translation_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (pending_translations.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual 0x%0h/0x%0h",
                        $time, rsp_tdata, rsp_tuser);
               fail_count++;
            end else begin
               want = pending_translations.pop_front();
               check_field("physical_address", want.phys, rsp_tdata[15:0]);
               check_field("frame_index", 16'(want.frame), 16'(rsp_tdata[23:16]));
               check_field("tlb_hit", 16'(want.hit), 16'(rsp_tuser[USER_TLB_HIT]));
               check_field("page_fault", 16'(want.fault), 16'(rsp_tuser[USER_PAGE_FAULT]));
               check_field("hit_count", want.hits, rsp_tdata[39:24]);
               check_field("fault_count", want.faults, rsp_tdata[55:40]);
            end
         end
         if (stall_request) begin
            stall_left    = STALL_CYCLES;
            stall_request = 1'b0;
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= !idle_on || ($urandom_range(99) >= 29);
         end
      end
   end

   // Watchdog on cycles without any transfer
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // First touches fault, repeats hit; address extremes
   task automatic test_fault_and_hit();
      send_address(16'h0000);
      send_address(16'h00FF);
      send_address(16'hFFFF);
      send_address(16'hFF00);
      send_address(16'h1234);
      send_address(16'h12CB);
   endtask

   // Wrap the fill pointer so entry 0 is replaced, then walk the page table
   task automatic test_tlb_eviction();
      for (int p = 8'h20; p < 8'h2E; p++) send_address({8'(p), 8'(p * 7)});
      send_address(16'h005A);   // evicted from the TLB, still mapped; refills entry 1
      send_address(16'hFF80);   // entry 1 was just refilled, so this misses too
      send_address(16'h2D11);   // lives in entry 0 now
   endtask

   // Working-set traffic mixed with fully random addresses
   task automatic test_random_traffic();
      logic [7:0] page_pool [POOL_MAX];
      int         pool_size;
      for (int i = 0; i < POOL_MAX; i++) page_pool[i] = 8'($urandom);
      pool_size = 8;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0) begin
            pool_size = $urandom_range(POOL_MAX, 4);
            for (int k = 0; k < 4; k++) page_pool[$urandom_range(POOL_MAX - 1)] = 8'($urandom);
         end
         // back-to-back stretch in the middle
         idle_on = !(n >= 600 && n < 900);
         if ($urandom_range(99) < 60)
            send_address({page_pool[$urandom_range(pool_size - 1)], 8'($urandom)});
         else
            send_address(16'($urandom));
      end
      idle_on = 1'b1;
   endtask

   // Hold the result side off while addresses keep coming
   task automatic test_output_stall();
      stall_request = 1'b1;
      for (int n = 0; n < 30; n++) send_address(16'($urandom));
      req_tvalid <= 1'b0;
      wait_for_results();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_fault_and_hit();
      test_tlb_eviction();
      test_random_traffic();
      test_output_stall();
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
